>>> rtl/rgbhsl_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Widths, constants and shared types of the rgb to hsl converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsl_pkg;

   localparam int ChanWidth     = 8;
   localparam int HueWidth      = 15;
   localparam int FracWidth     = 16;
   localparam int SumWidth      = ChanWidth + 1;

   // hue in 1/64 degree, one sextant is 60 degrees
   localparam int HueFullTurn   = 23040;
   localparam int HuePerSextant = 3840;

   // divider: numerator, divisor, quotient and reciprocal widths
   localparam int DivNumWidth   = 24;
   localparam int DivDenWidth   = ChanWidth;
   localparam int DivQuoWidth   = FracWidth;
   localparam int RecipWidth    = DivNumWidth + 1;
   localparam int RecipDepth    = 1 << DivDenWidth;

   // operands handed from the front end to the dividers
   typedef struct packed {
      logic [DivNumWidth-1:0] hue_num;
      logic [DivDenWidth-1:0] hue_den;
      logic [DivNumWidth-1:0] sat_num;
      logic [DivDenWidth-1:0] sat_den;
      logic [FracWidth-1:0]   light;
      logic                   grey;
   } prep_type;

endpackage

`default_nettype wire

>>> rtl/rgbhsl_if.sv
// ----------------------------------------------------------------------------
// rgbhsl_if
// Valid/ready channels of the converter: rgb pixel in, hsl result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbhsl_pix_if;
   logic                              valid;
   logic                              ready;
   logic [rgbhsl_pkg::ChanWidth-1:0] red;
   logic [rgbhsl_pkg::ChanWidth-1:0] green;
   logic [rgbhsl_pkg::ChanWidth-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsl_hsl_if;
   logic                              valid;
   logic                              ready;
   logic [rgbhsl_pkg::HueWidth-1:0]  hue;
   logic [rgbhsl_pkg::FracWidth-1:0] saturation;
   logic [rgbhsl_pkg::FracWidth-1:0] lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/rgb_to_hsl_converter_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_top
// RGB pixel to hue, saturation and lightness, one pixel per clock unless rsp stalls.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one rgb pixel of 8 bits per channel per item, rsp one hsl result per item,
//   both valid/ready; an item moves when valid and ready are high at a
//   rising clock edge. Results leave in the order the pixels came in.
//   hue is in 1/64 degree (0..23039), saturation and lightness are
//   fractions scaled by 65535, all rounded to nearest.
//   Results pass through five register stages: max/min, division operands,
//   reciprocal multiply, remainder correction and the output register.
//   Throughput is one item per cycle while rsp is not stalled; the pair of
//   dividers is fully pipelined.
//   A synchronous reset empties the pipeline; rsp.valid is low after it
//   and req.ready is high.
//   When the receiver holds rsp.ready low with a result waiting, the whole
//   pipeline freezes, empty stages included, and req.ready drops in the
//   same cycle, so a stall loses no item and repeats no result.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsl_converter_top (
   input wire logic      clock,
   input wire logic      reset,
   rgbhsl_pix_if.sink    req,
   rgbhsl_hsl_if.source  rsp
);

   localparam int HW    = rgbhsl_pkg::HueWidth;
   localparam int FW    = rgbhsl_pkg::FracWidth;
   localparam int QW    = rgbhsl_pkg::DivQuoWidth;
   localparam int Depth = 5;

   logic                 adv;
   logic [Depth-1:0]     valid_in, valid_ff;
   rgbhsl_pkg::prep_type prep;
   logic [QW-1:0]        hue_q;
   logic [QW-1:0]        sat_q;
   logic [FW-1:0]        light_d3_ff, light_d4_ff;
   logic                 grey_d3_ff, grey_d4_ff;
   logic [HW-1:0]        hue_in, hue_ff;
   logic [FW-1:0]        sat_in, sat_ff;
   logic [FW-1:0]        light_ff;

   // the output stage frees up whenever it is empty or being taken
   assign adv       = !valid_ff[Depth-1] || rsp.ready;
   assign req.ready = adv;

   assign valid_in = {valid_ff[Depth-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   rgbhsl_front u_front (
      .clock (clock),
      .en    (adv),
      .red   (req.red),
      .green (req.green),
      .blue  (req.blue),
      .prep  (prep)
   );

   rgbhsl_div u_hue_div (
      .clock (clock),
      .en    (adv),
      .num   (prep.hue_num),
      .den   (prep.hue_den),
      .quo   (hue_q)
   );

   rgbhsl_div u_sat_div (
      .clock (clock),
      .en    (adv),
      .num   (prep.sat_num),
      .den   (prep.sat_den),
      .quo   (sat_q)
   );

   // lightness and grey flag ride alongside the divider stages
   always_ff @(posedge clock) begin
      if (adv) begin
         light_d3_ff <= prep.light;
         grey_d3_ff  <= prep.grey;
         light_d4_ff <= light_d3_ff;
         grey_d4_ff  <= grey_d3_ff;
      end
   end

   // grey pixels get no hue or saturation, a full turn wraps to zero
   assign hue_in = (grey_d4_ff || hue_q >= QW'(rgbhsl_pkg::HueFullTurn)) ?
                   '0 : hue_q[HW-1:0];
   assign sat_in = grey_d4_ff ? '0 : sat_q;

   always_ff @(posedge clock) begin
      if (adv) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         light_ff <= light_d4_ff;
      end
   end

   assign rsp.valid      = valid_ff[Depth-1];
   assign rsp.hue        = hue_ff;
   assign rsp.saturation = sat_ff;
   assign rsp.lightness  = light_ff;

   a_hue_range : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.hue < HW'(rgbhsl_pkg::HueFullTurn))
      else $error("hue out of range");

   a_hue_needs_sat : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.hue != '0 |-> rsp.saturation != '0)
      else $error("nonzero hue with zero saturation");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid right after reset");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("item taken while output stalled");

endmodule

`default_nettype wire

>>> rtl/rgbhsl_front.sv
// ----------------------------------------------------------------------------
// rgbhsl_front
// Two pipeline stages: channel max/min and sextant select, then the
// rounded division operands for hue and saturation and the lightness.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsl_front (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic [rgbhsl_pkg::ChanWidth-1:0] red,
   input  wire logic [rgbhsl_pkg::ChanWidth-1:0] green,
   input  wire logic [rgbhsl_pkg::ChanWidth-1:0] blue,
   output rgbhsl_pkg::prep_type                   prep
);

   localparam int CW = rgbhsl_pkg::ChanWidth;
   localparam int SW = rgbhsl_pkg::SumWidth;
   localparam int NW = rgbhsl_pkg::DivNumWidth;
   localparam int FW = rgbhsl_pkg::FracWidth;
   localparam int AW = CW + 3;

   // hue offset in sextants for the channel that holds the max
   localparam logic [2:0] SextRed     = 3'd0;
   localparam logic [2:0] SextGreen   = 3'd2;
   localparam logic [2:0] SextBlue    = 3'd4;
   localparam logic [2:0] SextRedWrap = 3'd6;

   // stage 1
   logic [CW-1:0]        mx;
   logic [CW-1:0]        mn;
   logic [CW-1:0]        d_in,    d_ff;
   logic [SW-1:0]        s_in,    s_ff;
   logic signed [SW-1:0] diff_in, diff_ff;
   logic [2:0]           sext_in, sext_ff;

   // stage 2
   logic [AW-1:0]        kd;
   logic signed [AW:0]   a_full;
   logic [AW-1:0]        a;
   logic [CW-1:0]        den;
   logic [SW+CW-1:0]     light_sum;
   rgbhsl_pkg::prep_type prep_in, prep_ff;

   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx)  mx = blue;
      if (green < mn) mn = green;
      if (blue < mn)  mn = blue;
      d_in = mx - mn;
      s_in = SW'(mx) + SW'(mn);
      priority if (mx == red) begin
         diff_in = $signed({1'b0, green}) - $signed({1'b0, blue});
         sext_in = (diff_in < 0) ? SextRedWrap : SextRed;
      end else if (mx == green) begin
         diff_in = $signed({1'b0, blue}) - $signed({1'b0, red});
         sext_in = SextGreen;
      end else begin
         diff_in = $signed({1'b0, red}) - $signed({1'b0, green});
         sext_in = SextBlue;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in;
         s_ff    <= s_in;
         diff_ff <= diff_in;
         sext_ff <= sext_in;
      end
   end

   always_comb begin
      // hue numerator in sextants, never negative after the wrap offset
      kd     = AW'(sext_ff) * AW'(d_ff);
      a_full = (AW+1)'(diff_ff) + $signed({1'b0, kd});
      a      = a_full[AW-1:0];
      den    = (s_ff <= SW'(255)) ? s_ff[CW-1:0] : CW'(SW'(510) - s_ff);
      // (257*s + 1) / 2 is s * 65535 / 510 rounded
      light_sum = (SW+CW)'({s_ff, 8'b0}) + (SW+CW)'(s_ff) + (SW+CW)'(1);

      prep_in.hue_num = NW'({a, 12'b0}) - NW'({a, 8'b0}) + NW'(d_ff[CW-1:1]);
      prep_in.hue_den = d_ff;
      prep_in.sat_num = NW'({d_ff, 16'b0}) - NW'(d_ff) + NW'(den[CW-1:1]);
      prep_in.sat_den = den;
      prep_in.light   = light_sum[FW:1];
      prep_in.grey    = (d_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_ff <= prep_in;
      end
   end

   assign prep = prep_ff;

endmodule

`default_nettype wire

>>> rtl/rgbhsl_div.sv
// ----------------------------------------------------------------------------
// rgbhsl_div
// Two-stage divider by an 8-bit divisor: reciprocal multiply for an
// estimate that is at most one low, then a remainder check to correct it.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsl_div (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic [rgbhsl_pkg::DivNumWidth-1:0] num,
   input  wire logic [rgbhsl_pkg::DivDenWidth-1:0] den,
   output      logic [rgbhsl_pkg::DivQuoWidth-1:0] quo
);

   localparam int NW = rgbhsl_pkg::DivNumWidth;
   localparam int DW = rgbhsl_pkg::DivDenWidth;
   localparam int QW = rgbhsl_pkg::DivQuoWidth;
   localparam int RW = rgbhsl_pkg::RecipWidth;
   localparam int PW = NW + RW;

   // floor(2^24 / d); the zero entry is never used for a valid result
   logic [RW-1:0] recip_rom [rgbhsl_pkg::RecipDepth];

   for (genvar i = 0; i < rgbhsl_pkg::RecipDepth; i++) begin : g_recip
      localparam logic [RW-1:0] RcVal = RW'((1 << NW) / ((i == 0) ? 1 : i));
      assign recip_rom[i] = RcVal;
   end

   logic [PW-1:0] prod;
   logic [QW-1:0] q_est_in, q_est_ff;
   logic [NW-1:0] num_ff;
   logic [DW-1:0] den_ff;
   logic [NW-1:0] back;
   logic [NW-1:0] rem;
   logic [QW-1:0] quo_in, quo_ff;

   assign prod     = num * recip_rom[den];
   assign q_est_in = prod[NW +: QW];

   always_ff @(posedge clock) begin
      if (en) begin
         q_est_ff <= q_est_in;
         num_ff   <= num;
         den_ff   <= den;
      end
   end

   assign back   = q_est_ff * den_ff;
   assign rem    = num_ff - back;
   assign quo_in = (rem >= NW'(den_ff)) ? q_est_ff + QW'(1) : q_est_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire
